### rtl/core/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
// Used by bhpq_level_cell and binary_heap_priority_queue; depends on nothing.
`default_nettype none

package bhpq_pkg;

    // Defaults for the top-level parameters and the largest supported heap.
    localparam int MAX_CAPACITY    = 64;
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Index of an entry within one heap level, sized for the largest heap.
    localparam int IDX_W = $clog2(MAX_CAPACITY);

    // Fixed widths of the stream fields.
    localparam int FIELD_W = 32;
    localparam int FILL_W  = 7;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // Request kinds carried in s_tuser.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DRAIN  = 2'd2
    } op_t;

    // Result kinds carried in m_tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_INJECT,
        S_SIFT,
        S_EMIT
    } state_t;

    // A hole that travels along the chain: which entry of a level it sits on.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } tok_t;

    // Write command into a level's storage.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } wr_t;

endpackage

`default_nettype wire

### rtl/core/bhpq_level_cell.sv
// One level of the heap: holds that level's entries and moves a hole up or down.
// Depends on bhpq_pkg for the hole and write-command structs.
`default_nettype none

module bhpq_level_cell #(
    parameter int LEVEL       = 0,
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             top_is_largest,
    input  logic [$clog2(CAPACITY+1)-1:0]    heap_n,
    input  logic [$clog2(CAPACITY+1)-1:0]    peek_pos,
    // Hole one level up, looking for a winning child in this level.
    input  bhpq_pkg::tok_t                   dn_in,
    input  logic [VALUE_WIDTH-1:0]           dn_in_val,
    // Hole one level down, comparing against its parent in this level.
    input  bhpq_pkg::tok_t                   up_in,
    input  logic [VALUE_WIDTH-1:0]           up_in_val,
    // Write into this level.
    input  bhpq_pkg::wr_t                    wr_in,
    input  logic [VALUE_WIDTH-1:0]           wr_in_data,
    // Hole handed to the next level down and up.
    output bhpq_pkg::tok_t                   dn_out,
    output logic [VALUE_WIDTH-1:0]           dn_out_val,
    output bhpq_pkg::tok_t                   up_out,
    output logic [VALUE_WIDTH-1:0]           up_out_val,
    // Writes into the neighbor levels.
    output bhpq_pkg::wr_t                    wr_up,
    output logic [VALUE_WIDTH-1:0]           wr_up_data,
    output bhpq_pkg::wr_t                    wr_dn,
    output logic [VALUE_WIDTH-1:0]           wr_dn_data,
    // Read-back for the sequencer.
    output logic [VALUE_WIDTH-1:0]           root_val,
    output logic                             peek_hit,
    output logic [VALUE_WIDTH-1:0]           peek_val
);
    import bhpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam int EXT_W = CNT_W + 2;
    localparam int BASE  = 2**LEVEL - 1;
    localparam int FULL  = 2**LEVEL;
    localparam int SIZE  = (CAPACITY - BASE < FULL) ? (CAPACITY - BASE) : FULL;
    localparam int ROWS  = (SIZE + 1) / 2;
    localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VW    = VALUE_WIDTH;

    // Entries are kept as sibling pairs so both children come out of one row.
    logic [2*VW-1:0] rows_reg [ROWS];

    tok_t            dn_out_reg, dn_out_next;
    tok_t            up_out_reg, up_out_next;
    logic [VW-1:0]   dn_val_reg, dn_val_next;
    logic [VW-1:0]   up_val_reg, up_val_next;

    logic [EXT_W-1:0] peek_ext, peek_local, peek_row_full, left_pos, n_ext;
    logic [IDX_W-1:0] par_idx, par_row_full, wr_row_full;
    logic [IDX_W-1:0] child_idx;
    logic [RA_W-1:0]  rd_addr, wr_row;
    logic [2*VW-1:0]  rd_row;
    logic signed [VW-1:0] lane0, lane1, child, parent;
    logic             left_ok, right_ok, take_right, win_dn, win_up;

    // Strict win of a over b under the configured order.
    function automatic logic beats(input logic largest,
                                   input logic signed [VW-1:0] a,
                                   input logic signed [VW-1:0] b);
        beats = largest ? (a > b) : (a < b);
    endfunction

    // Position decode for the sequencer's read-back.
    always_comb begin
        peek_ext      = EXT_W'(peek_pos);
        peek_hit      = (peek_ext >= EXT_W'(BASE)) && (peek_ext < EXT_W'(BASE + SIZE));
        peek_local    = peek_ext - EXT_W'(BASE);
        peek_row_full = peek_local >> 1;
        par_idx       = up_in.idx >> 1;
        par_row_full  = par_idx >> 1;
    end

    // One row read per cycle; the active hole has priority over read-back.
    always_comb begin
        if (dn_in.valid) begin
            rd_addr = dn_in.idx[RA_W-1:0];
        end else if (up_in.valid) begin
            rd_addr = par_row_full[RA_W-1:0];
        end else if (peek_hit) begin
            rd_addr = peek_row_full[RA_W-1:0];
        end else begin
            rd_addr = '0;
        end
        rd_row   = rows_reg[rd_addr];
        lane0    = rd_row[VW-1:0];
        lane1    = rd_row[2*VW-1:VW];
        root_val = lane0;
        peek_val = peek_local[0] ? lane1 : lane0;
    end

    // Sift-down step: pick the stronger child and decide whether it moves up.
    always_comb begin
        n_ext      = EXT_W'(heap_n);
        left_pos   = EXT_W'(BASE) + EXT_W'({dn_in.idx, 1'b0});
        left_ok    = left_pos < n_ext;
        right_ok   = (left_pos + EXT_W'(1)) < n_ext;
        take_right = right_ok && beats(top_is_largest, lane1, lane0);
        child      = take_right ? lane1 : lane0;
        win_dn     = left_ok && beats(top_is_largest, child, dn_in_val);
        child_idx  = {dn_in.idx[IDX_W-2:0], take_right};

        wr_up       = '{en: dn_in.valid, idx: dn_in.idx};
        wr_up_data  = win_dn ? child : dn_in_val;
        dn_out_next = '{valid: dn_in.valid && win_dn, idx: child_idx};
        dn_val_next = dn_in_val;
    end

    // Sift-up step: the moving value climbs only past a parent it strictly beats.
    always_comb begin
        parent      = par_idx[0] ? lane1 : lane0;
        win_up      = beats(top_is_largest, up_in_val, parent);
        wr_dn       = '{en: up_in.valid, idx: up_in.idx};
        wr_dn_data  = win_up ? parent : up_in_val;
        up_out_next = '{valid: up_in.valid && win_up, idx: par_idx};
        up_val_next = up_in_val;
    end

    // Level storage, one entry written per cycle.
    always_comb begin
        wr_row_full = wr_in.idx >> 1;
        wr_row      = wr_row_full[RA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_in.en) begin
            if (wr_in.idx[0]) begin
                rows_reg[wr_row][2*VW-1:VW] <= wr_in_data;
            end else begin
                rows_reg[wr_row][VW-1:0] <= wr_in_data;
            end
        end
    end

    // Hole registers toward the neighbors.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_out_reg <= '0;
            up_out_reg <= '0;
        end else begin
            dn_out_reg <= dn_out_next;
            up_out_reg <= up_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        dn_val_reg <= dn_val_next;
        up_val_reg <= up_val_next;
    end

    assign dn_out     = dn_out_reg;
    assign dn_out_val = dn_val_reg;
    assign up_out     = up_out_reg;
    assign up_out_val = up_val_reg;

endmodule

`default_nettype wire

### rtl/core/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, stream ports and level chain.
// Depends on bhpq_pkg and instantiates one bhpq_level_cell per heap level.
//
//   Channel   Direction  Ports                          Contents
//   s_        in         s_tvalid s_tready s_tdata      tdata: item_value; tuser: operation
//                        s_tuser
//   m_        out        m_tvalid m_tready m_tdata      tdata: result_value, fill_level;
//                        m_tuser m_tlast                tuser: status; tlast: last_of_run
//   cfg_      in         cfg_we cfg_wdata               top_is_largest
//
// A request is taken only while the sequencer is idle and is worked on alone.
// An insert into a full heap and a pop of a heap with at most one value go straight from
// the load state to the emit state; any other insert or pop passes through the inject and
// sift states, where the hole walks down or up the level chain one level per cycle; a drain
// repeats the pop loop once per stored value.
// Reset is synchronous, active low; it empties the heap and sets largest-on-top.
// A stalled m_ side holds the finished result in the output register and the
// sequencer waits in its emit state until that register is free.
`default_nettype none

module binary_heap_priority_queue #(
    parameter int CAPACITY    = bhpq_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = bhpq_pkg::DEF_VALUE_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: bit 0 = top_is_largest.
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] item_value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [38:32] fill_level, [39] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_of_run
);
    import bhpq_pkg::*;

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int CNT_W  = LEVELS;
    localparam int EXT_W  = CNT_W + 2;
    localparam int VW     = VALUE_WIDTH;
    localparam int OUT_W  = 40;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    status_t               status_reg, status_next;
    logic [VW-1:0]         moving_reg, moving_next;
    logic [VW-1:0]         result_reg, result_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  largest_reg;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic [STAT_W-1:0]     m_tuser_reg;
    logic                  m_tlast_reg;

    logic [VW-1:0]         item_val;
    logic [FIELD_W-1:0]    result_32;
    logic                  out_free, out_load, more, full, busy;
    logic                  inject_ins, inject_dn, ins_root;
    logic [CNT_W-1:0]      peek_pos;
    logic [VW-1:0]         last_val;

    // Chain wiring, one element per level.
    tok_t                  dn_tok [LEVELS];
    tok_t                  up_tok [LEVELS];
    logic [VW-1:0]         dn_val [LEVELS];
    logic [VW-1:0]         up_val [LEVELS];
    wr_t                   wu [LEVELS];
    wr_t                   wd [LEVELS];
    logic [VW-1:0]         wu_data [LEVELS];
    logic [VW-1:0]         wd_data [LEVELS];
    logic [VW-1:0]         root_v [LEVELS];
    logic                  peek_hit [LEVELS];
    logic [VW-1:0]         peek_v [LEVELS];

    // Value width conversion on both streams.
    generate
        if (VW <= FIELD_W) begin : g_in_narrow
            assign item_val = s_tdata[VW-1:0];
        end else begin : g_in_wide
            assign item_val = {{(VW - FIELD_W){s_tdata[FIELD_W-1]}}, s_tdata};
        end
        if (VW >= FIELD_W) begin : g_out_wide
            assign result_32 = result_reg[FIELD_W-1:0];
        end else begin : g_out_narrow
            assign result_32 = {{(FIELD_W - VW){result_reg[VW-1]}}, result_reg};
        end
    endgenerate

    // Sequencer status terms.
    always_comb begin
        full     = count_reg == CNT_W'(CAPACITY);
        more     = (op_reg == OP_DRAIN) && (count_reg != '0);
        out_free = !m_tvalid_reg || m_tready;
        peek_pos = count_reg - CNT_W'(1);
        busy     = 1'b0;
        last_val = '0;
        for (int l = 0; l < LEVELS; l++) begin
            busy = busy | dn_tok[l].valid | up_tok[l].valid;
            if (peek_hit[l]) begin
                last_val = last_val | peek_v[l];
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                case (op_reg)
                    OP_INSERT: state_next = full ? S_EMIT : S_INJECT;
                    OP_POP, OP_DRAIN: begin
                        state_next = (count_reg <= CNT_W'(1)) ? S_EMIT : S_INJECT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_INJECT: state_next = S_SIFT;
            S_SIFT: begin
                if (!busy) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = more ? S_LOAD : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready   = state_reg == S_IDLE;
        inject_ins = (state_reg == S_INJECT) && (op_reg == OP_INSERT);
        inject_dn  = (state_reg == S_INJECT) && (op_reg != OP_INSERT);
        ins_root   = inject_ins && (count_reg == '0);
        out_load   = (state_reg == S_EMIT) && out_free;
    end

    // Request and result bookkeeping.
    always_comb begin
        op_next     = op_reg;
        status_next = status_reg;
        moving_next = moving_reg;
        result_next = result_reg;
        count_next  = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = op_t'(s_tuser);
                    moving_next = item_val;
                end
            end
            S_LOAD: begin
                result_next = '0;
                case (op_reg)
                    OP_INSERT: status_next = full ? ST_FULL : ST_INSERTED;
                    OP_POP, OP_DRAIN: begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            status_next = ST_POPPED;
                            result_next = root_v[0];
                            moving_next = last_val;
                            count_next  = count_reg - CNT_W'(1);
                        end
                    end
                    default: status_next = status_reg;
                endcase
            end
            S_INJECT: begin
                if (op_reg == OP_INSERT) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default: count_next = count_reg;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            largest_reg  <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we) begin
                largest_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        status_reg <= status_next;
        moving_reg <= moving_next;
        result_reg <= result_next;
        if (out_load) begin
            m_tdata_reg <= {1'b0, FILL_W'(count_reg), result_32};
            m_tuser_reg <= status_reg;
            m_tlast_reg <= !more;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The level chain.
    generate
        for (genvar L = 0; L < LEVELS; L++) begin : g_lvl
            localparam int CB = 2**(L+1) - 1;
            localparam int CS = 2**(L+1);

            tok_t           dn_in, up_in;
            logic [VW-1:0]  dn_in_val, up_in_val;
            wr_t            below_w, above_w, wr_in;
            logic [VW-1:0]  below_d, above_d, wr_in_data;
            logic [EXT_W-1:0] cnt_ext, ins_off;
            logic           ins_hit;

            // An insert whose new slot sits one level below this one starts here.
            always_comb begin
                cnt_ext = EXT_W'(count_reg);
                ins_off = cnt_ext - EXT_W'(CB);
                ins_hit = inject_ins && (cnt_ext >= EXT_W'(CB))
                          && (cnt_ext < EXT_W'(CB + CS));
            end

            // Hole coming down from the level above.
            if (L == 0) begin : g_dn_top
                assign dn_in     = '0;
                assign dn_in_val = moving_reg;
            end else if (L == 1) begin : g_dn_first
                assign dn_in     = inject_dn ? tok_t'{valid: 1'b1, idx: '0} : dn_tok[0];
                assign dn_in_val = inject_dn ? moving_reg : dn_val[0];
            end else begin : g_dn_mid
                assign dn_in     = dn_tok[L-1];
                assign dn_in_val = dn_val[L-1];
            end

            // Hole coming up from the level below, or a fresh insert.
            if (L + 1 < LEVELS) begin : g_up_mid
                assign up_in     = ins_hit ? tok_t'{valid: 1'b1, idx: IDX_W'(ins_off)}
                                           : up_tok[L+1];
                assign up_in_val = ins_hit ? moving_reg : up_val[L+1];
            end else begin : g_up_last
                assign up_in     = '{valid: ins_hit, idx: IDX_W'(ins_off)};
                assign up_in_val = moving_reg;
            end

            // Writes arriving from below: a child moving up, or the final
            // placement of a hole that left the deepest level.
            if (L + 1 < LEVELS) begin : g_wr_below
                assign below_w = wu[L+1];
                assign below_d = wu_data[L+1];
            end else begin : g_wr_deep
                assign below_w = '{en: dn_tok[L].valid, idx: dn_tok[L].idx};
                assign below_d = dn_val[L];
            end

            // Writes arriving from above: a parent moving down, or the root
            // placement of an upward hole or of an insert into an empty heap.
            if (L > 0) begin : g_wr_above
                assign above_w = wd[L-1];
                assign above_d = wd_data[L-1];
            end else begin : g_wr_root
                assign above_w = '{en: up_tok[0].valid || ins_root,
                                   idx: ins_root ? '0 : up_tok[0].idx};
                assign above_d = ins_root ? moving_reg : up_val[0];
            end

            assign wr_in      = below_w.en ? below_w : above_w;
            assign wr_in_data = below_w.en ? below_d : above_d;

            bhpq_level_cell #(
                .LEVEL       (L),
                .CAPACITY    (CAPACITY),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .top_is_largest (largest_reg),
                .heap_n         (count_reg),
                .peek_pos       (peek_pos),
                .dn_in          (dn_in),
                .dn_in_val      (dn_in_val),
                .up_in          (up_in),
                .up_in_val      (up_in_val),
                .wr_in          (wr_in),
                .wr_in_data     (wr_in_data),
                .dn_out         (dn_tok[L]),
                .dn_out_val     (dn_val[L]),
                .up_out         (up_tok[L]),
                .up_out_val     (up_val[L]),
                .wr_up          (wu[L]),
                .wr_up_data     (wu_data[L]),
                .wr_dn          (wd[L]),
                .wr_dn_data     (wd_data[L]),
                .root_val       (root_v[L]),
                .peek_hit       (peek_hit[L]),
                .peek_val       (peek_v[L])
            );
        end
    endgenerate

endmodule

`default_nettype wire

### dv/bhpq_outcome_check.sv
`timescale 1ns / 100ps
// Result checker for the binary heap priority queue: keeps its own heap, predicts every result.
// Depends on bhpq_pkg; instantiated beside the block by binary_heap_priority_queue_test.

module bhpq_outcome_check #(
    parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          error_count,
    output int          pending
);
    import bhpq_pkg::*;

    // One result as the block should send it.
    typedef struct packed {
        logic [31:0]        value;
        status_t            status;
        logic [FILL_W-1:0]  fill;
        logic               last;
    } heap_outcome_t;

    // Mirror of the block's heap and its order setting.
    logic signed [31:0] heap_vals [CAPACITY];
    int                 heap_size;
    bit                 largest_on_top;
    heap_outcome_t      outcomes_q [$];
    int                 fails;

    // True when a strictly wins over b under the current order.
    function automatic bit outranks(input logic signed [31:0] a, input logic signed [31:0] b);
        return largest_on_top ? (a > b) : (a < b);
    endfunction

    task automatic expect_outcome(input logic [31:0] value, input status_t status,
                                  input bit last);
        heap_outcome_t o;
        o.value  = value;
        o.status = status;
        o.fill   = heap_size[FILL_W-1:0];
        o.last   = last;
        outcomes_q.push_back(o);
    endtask

    // Move a new entry toward the root; an equal parent stops it.
    task automatic sift_toward_root(input int start);
        logic signed [31:0] moving;
        int                 pos;
        int                 parent;
        bit                 done;
        pos    = start;
        moving = heap_vals[pos];
        done   = 1'b0;
        while (!done && pos > 0) begin
            parent = (pos - 1) / 2;
            if (!outranks(moving, heap_vals[parent])) begin
                done = 1'b1;
            end else begin
                heap_vals[pos] = heap_vals[parent];
                pos = parent;
            end
        end
        heap_vals[pos] = moving;
    endtask

    // Sink the root; the right child is taken only if it strictly wins.
    task automatic sift_toward_leaves(input int n);
        logic signed [31:0] moving;
        int                 pos;
        int                 child;
        bit                 done;
        pos    = 0;
        child  = 1;
        moving = heap_vals[0];
        done   = 1'b0;
        while (!done && child < n) begin
            if (child + 1 < n && outranks(heap_vals[child + 1], heap_vals[child]))
                child = child + 1;
            if (!outranks(heap_vals[child], moving)) begin
                done = 1'b1;
            end else begin
                heap_vals[pos] = heap_vals[child];
                pos   = child;
                child = 2 * pos + 1;
            end
        end
        heap_vals[pos] = moving;
    endtask

    task automatic remove_top(output logic [31:0] top);
        top = heap_vals[0];
        heap_size = heap_size - 1;
        heap_vals[0] = heap_vals[heap_size];
        if (heap_size > 0)
            sift_toward_leaves(heap_size);
    endtask

    // Work out every result that one accepted request causes.
    task automatic compute_heap_request(input logic [1:0] op, input logic [31:0] value);
        logic [31:0] top;
        case (op)
            OP_INSERT: begin
                if (heap_size >= CAPACITY) begin
                    expect_outcome('0, ST_FULL, 1'b1);
                end else begin
                    heap_vals[heap_size] = value;
                    heap_size = heap_size + 1;
                    sift_toward_root(heap_size - 1);
                    expect_outcome('0, ST_INSERTED, 1'b1);
                end
            end
            OP_POP: begin
                if (heap_size == 0) begin
                    expect_outcome('0, ST_EMPTY, 1'b1);
                end else begin
                    remove_top(top);
                    expect_outcome(top, ST_POPPED, 1'b1);
                end
            end
            OP_DRAIN: begin
                if (heap_size == 0)
                    expect_outcome('0, ST_EMPTY, 1'b1);
                while (heap_size > 0) begin
                    remove_top(top);
                    expect_outcome(top, ST_POPPED, heap_size == 0);
                end
            end
            default: ;
        endcase
    endtask

    // Compare results as they leave, then record new requests and register writes.
    always @(posedge aclk) begin
        heap_outcome_t want;
        if (!aresetn) begin
            heap_size      = 0;
            largest_on_top = 1'b1;
            outcomes_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (outcomes_q.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("check: result with nothing outstanding: value %0d status %0d",
                                 $signed(m_tdata[31:0]), m_tuser);
                end else begin
                    want = outcomes_q.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tuser !== want.status ||
                        m_tdata[38:32] !== want.fill || m_tlast !== want.last) begin
                        fails = fails + 1;
                        if (fails <= 10) begin
                            $display("check: mismatch: expected value %0d status %0d fill %0d last %0b",
                                     $signed(want.value), want.status, want.fill, want.last);
                            $display("check:           got value %0d status %0d fill %0d last %0b",
                                     $signed(m_tdata[31:0]), m_tuser, m_tdata[38:32], m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                compute_heap_request(s_tuser, s_tdata);
            if (cfg_we)
                largest_on_top = cfg_wdata;
        end
        error_count <= fails;
        pending     <= outcomes_q.size();
    end

    initial fails = 0;

endmodule

### dv/binary_heap_priority_queue_test.sv
`timescale 1ns / 100ps
// Top of the heap queue testbench: clock, reset, request and result traffic, final verdict.
// Depends on bhpq_pkg, binary_heap_priority_queue and bhpq_outcome_check.

module binary_heap_priority_queue_test;
    import bhpq_pkg::*;

    localparam int          DEPTH         = DEF_CAPACITY;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          RUN_ITEMS     = 500;
    localparam int          CYCLE_LIMIT   = 4_000_000;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [31:0] VAL_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN       = 32'h8000_0000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int error_count;
    int pending;
    int sent;
    int cycle_count = 0;
    bit steady      = 1'b0;

    binary_heap_priority_queue #(
        .CAPACITY    (DEPTH),
        .VALUE_WIDTH (DEF_VALUE_WIDTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    bhpq_outcome_check #(
        .CAPACITY (DEPTH)
    ) outcome_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .pending     (pending)
    );

    always #10 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before taking each result.
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Mix of extremes, small values that collide often, and full-range values.
    function automatic logic [31:0] pick_value(input bit narrow);
        int v;
        if (narrow) begin
            v = $urandom_range(0, 8);
            return v - 4;
        end
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one request after a random gap and hold it until the block takes it.
    task automatic send_request(input logic [1:0] op, input logic [31:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op != OP_UNUSED)
            sent = sent + 1;
    endtask

    // Stop sending until every predicted result is out and the block has gone quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_order(input bit largest);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= largest;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Fill past capacity, take a few off the top, and sometimes empty it all.
    task automatic fill_phase();
        bit narrow;
        narrow = $urandom_range(0, 1);
        repeat (DEPTH + $urandom_range(1, 3)) send_request(OP_INSERT, pick_value(narrow));
        repeat ($urandom_range(0, 5)) send_request(OP_POP, $urandom());
        if ($urandom_range(0, 1))
            send_request(OP_DRAIN, $urandom());
    endtask

    // Mostly inserts and pops, with the odd drain and unused code.
    task automatic mixed_phase();
        bit narrow;
        int r;
        narrow = ($urandom_range(0, 2) == 0);
        repeat (16) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_request(OP_INSERT, pick_value(narrow));
            else if (r < 88)
                send_request(OP_POP, $urandom());
            else if (r < 95)
                send_request(OP_DRAIN, $urandom());
            else
                send_request(OP_UNUSED, $urandom());
        end
    endtask

    initial begin
        bit first_phase;
        sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty heap, extremes and ties, unused code, order flip while filled.
        send_request(OP_POP, '1);
        send_request(OP_DRAIN, '0);
        send_request(OP_INSERT, 32'd5);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, VAL_MAX);
        send_request(OP_INSERT, 32'd1);
        send_request(OP_UNUSED, '1);
        send_request(OP_POP, '0);
        set_order(1'b0);
        send_request(OP_POP, '0);
        send_request(OP_POP, '0);
        send_request(OP_INSERT, VAL_MIN);
        send_request(OP_INSERT, '1);
        send_request(OP_DRAIN, '0);
        set_order(1'b1);

        // Random phases; the first one always runs the heap full.
        first_phase = 1'b1;
        while (sent < RUN_ITEMS) begin
            if ($urandom_range(0, 2) == 0)
                set_order($urandom_range(0, 1));
            else if ($urandom_range(0, 3) == 0)
                wait_idle();
            steady = ($urandom_range(0, 3) == 0);
            if (first_phase || $urandom_range(0, 9) == 0)
                fill_phase();
            else
                mixed_phase();
            first_phase = 1'b0;
        end
        steady = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
